>>> rtl/tcsp_pkg.sv
// Shared types and constants for the track cache slot policy block.
`timescale 1ns / 1ps
package tcsp_pkg;

    localparam int OPCODE_W = 3;
    localparam int CYL_W    = 8;
    localparam int SECTOR_W = 5;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 18;
    localparam int KEY_W    = 10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACQUIRE       = 3'd0,
        OP_WRITE_SECTOR  = 3'd1,
        OP_MERGE_BEGIN   = 3'd2,
        OP_MERGE_SECTOR  = 3'd3,
        OP_FLUSH_DONE    = 3'd4,
        OP_NEXT_DIRTY    = 3'd5,
        OP_DISCARD_ALL   = 3'd6,
        OP_CLEAR_ALL     = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NEED_FLUSH = 2'd1,
        ST_CORRUPT    = 2'd2,
        ST_NONE_FOUND = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic scan_step;
        logic decide;
        logic exec;
        logic load_out;
    } tcsp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    bad_slot;
        logic    scan_last;
        logic    hit_now;
        logic    out_busy;
    } tcsp_stat_t;

endpackage

>>> rtl/tcsp_if.sv
// Valid/ready channel interfaces for command and result items.
`timescale 1ns / 1ps
interface tcsp_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] cylinder;
    logic       head;
    logic [4:0] sector;
    logic [2:0] slot_index;
    logic       authoritative;
    logic       fresh_present;
    logic       data_equal;

    modport source (
        output valid, opcode, cylinder, head, sector, slot_index,
               authoritative, fresh_present, data_equal,
        input  ready
    );
    modport sink (
        input  valid, opcode, cylinder, head, sector, slot_index,
               authoritative, fresh_present, data_equal,
        output ready
    );
endinterface

interface tcsp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  result_slot;
    logic        hit;
    logic [7:0]  victim_cylinder;
    logic        victim_head;
    logic [17:0] valid_mask;
    logic [17:0] dirty_mask;
    logic        copy_data;
    logic        any_dirty;

    modport source (
        output valid, status, result_slot, hit, victim_cylinder, victim_head,
               valid_mask, dirty_mask, copy_data, any_dirty,
        input  ready
    );
    modport sink (
        input  valid, status, result_slot, hit, victim_cylinder, victim_head,
               valid_mask, dirty_mask, copy_data, any_dirty,
        output ready
    );
endinterface

>>> rtl/tcsp_ctrl.sv
// Sequencing controller for the track cache slot policy block.
`timescale 1ns / 1ps
module tcsp_ctrl
    import tcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tcsp_stat_t stat,
    output tcsp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE,
        S_EXEC,
        S_REPORT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.bad_slot)
                begin
                    state_next = S_REPORT;
                end
                else if (stat.op == OP_ACQUIRE || stat.op == OP_NEXT_DIRTY)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.op == OP_ACQUIRE && stat.hit_now)
                begin
                    state_next = S_EXEC;
                end
                else if (stat.scan_last)
                begin
                    state_next = (stat.op == OP_ACQUIRE) ? S_DECIDE : S_REPORT;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tcsp_dp.sv
// Slot state storage, scan trackers and result register.
`timescale 1ns / 1ps
module tcsp_dp
    import tcsp_pkg::*;
#(
    parameter int TRACK_SLOTS       = 8,
    parameter int SECTORS_PER_TRACK = 18,
    parameter int HEAD_COUNT        = 2,
    parameter int STAMP_BITS        = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tcsp_cmd_t           cmd,
    output tcsp_stat_t          stat,
    input  logic [OPCODE_W-1:0] in_opcode,
    input  logic [CYL_W-1:0]    in_cylinder,
    input  logic                in_head,
    input  logic [SECTOR_W-1:0] in_sector,
    input  logic [SLOT_W-1:0]   in_slot_index,
    input  logic                in_authoritative,
    input  logic                in_fresh_present,
    input  logic                in_data_equal,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] out_status,
    output logic [SLOT_W-1:0]   out_result_slot,
    output logic                out_hit,
    output logic [CYL_W-1:0]    out_victim_cylinder,
    output logic                out_victim_head,
    output logic [MASK_W-1:0]   out_valid_mask,
    output logic [MASK_W-1:0]   out_dirty_mask,
    output logic                out_copy_data,
    output logic                out_any_dirty
);

    localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int SW = SECTORS_PER_TRACK;
    localparam int SB = STAMP_BITS;

    // Latched command item
    opcode_t             op_reg;
    logic [CYL_W-1:0]    cyl_reg;
    logic                head_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic [SLOT_W-1:0]   si_reg;
    logic                auth_reg;
    logic                fresh_reg;
    logic                equal_reg;

    // Slot state
    logic             occ_reg   [TRACK_SLOTS];
    logic [CYL_W-1:0] tag_cyl_reg  [TRACK_SLOTS];
    logic             tag_head_reg [TRACK_SLOTS];
    logic [SB-1:0]    stamp_reg [TRACK_SLOTS];
    logic [SW-1:0]    valid_reg [TRACK_SLOTS];
    logic [SW-1:0]    dirty_reg [TRACK_SLOTS];
    logic [SW-1:0]    conf_reg  [TRACK_SLOTS];
    logic [SB-1:0]    clock_reg;

    // Scan trackers
    logic [IW-1:0]    scan_idx_reg;
    logic [IW-1:0]    pick_reg;
    logic             hit_reg;
    logic             flush_reg;
    logic             corrupt_reg;
    logic             copy_reg;
    logic             empty_found_reg;
    logic [IW-1:0]    empty_idx_reg;
    logic             clean_found_reg;
    logic [IW-1:0]    clean_idx_reg;
    logic [SB-1:0]    clean_stamp_reg;
    logic             vic_found_reg;
    logic [IW-1:0]    vic_idx_reg;
    logic [SB-1:0]    vic_stamp_reg;
    logic             best_found_reg;
    logic [KEY_W-1:0] best_key_reg;

    // Result register
    logic                out_valid_reg;
    status_t             status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                rhit_reg;
    logic [CYL_W-1:0]    rcyl_reg;
    logic                rhead_reg;
    logic [MASK_W-1:0]   rvalid_reg;
    logic [MASK_W-1:0]   rdirty_reg;
    logic                rcopy_reg;
    logic                rany_reg;

    logic             op_slot;
    logic             bad_slot;
    logic             sec_ok;
    logic [SW-1:0]    sec_bit;
    logic [IW-1:0]    rd_idx;
    logic             r_occ;
    logic [CYL_W-1:0] r_cyl;
    logic             r_head;
    logic [SB-1:0]    r_stamp;
    logic [SW-1:0]    r_valid;
    logic [SW-1:0]    r_dirty;
    logic [SW-1:0]    r_conf;
    logic             hit_now;
    logic [KEY_W-1:0] r_key;
    logic [SW-1:0]    e_valid_next;
    logic [SW-1:0]    e_dirty_next;
    logic [SW-1:0]    e_conf_next;
    logic             e_copy;
    logic             e_corrupt;
    logic [SB-1:0]    clock_inc;
    logic             clock_wrap;
    logic             touch_en;
    logic             alloc_en;
    logic             zero_rep;
    logic             any_dirty;
    status_t          status_next;

    assign op_slot  = (op_reg == OP_WRITE_SECTOR) || (op_reg == OP_MERGE_BEGIN) ||
                      (op_reg == OP_MERGE_SECTOR) || (op_reg == OP_FLUSH_DONE);
    assign bad_slot = op_slot && (int'(si_reg) >= TRACK_SLOTS);
    assign sec_ok   = int'(sec_reg) < SECTORS_PER_TRACK;
    assign sec_bit  = SW'(1) << sec_reg;

    // One read port, address chosen by phase
    always_comb
    begin
        if (cmd.scan_step)
        begin
            rd_idx = scan_idx_reg;
        end
        else if (op_slot)
        begin
            rd_idx = IW'(si_reg);
        end
        else
        begin
            rd_idx = pick_reg;
        end
    end

    assign r_occ   = occ_reg[rd_idx];
    assign r_cyl   = tag_cyl_reg[rd_idx];
    assign r_head  = tag_head_reg[rd_idx];
    assign r_stamp = stamp_reg[rd_idx];
    assign r_valid = valid_reg[rd_idx];
    assign r_dirty = dirty_reg[rd_idx];
    assign r_conf  = conf_reg[rd_idx];

    assign hit_now = r_occ && (r_cyl == cyl_reg) && (r_head == head_reg);
    assign r_key   = KEY_W'(r_cyl) * KEY_W'(HEAD_COUNT) + KEY_W'(r_head);

    // Per-entry update for the sector and flush commands
    always_comb
    begin
        e_valid_next = r_valid;
        e_dirty_next = r_dirty;
        e_conf_next  = r_conf;
        e_copy       = 1'b0;
        e_corrupt    = 1'b0;
        case (op_reg)
            OP_WRITE_SECTOR:
            begin
                if (sec_ok)
                begin
                    e_valid_next = r_valid | sec_bit;
                    e_dirty_next = r_dirty | sec_bit;
                    e_conf_next  = r_conf & ~sec_bit;
                end
            end
            OP_MERGE_BEGIN:
            begin
                if (auth_reg)
                begin
                    e_conf_next = '0;
                end
            end
            OP_MERGE_SECTOR:
            begin
                if (sec_ok && fresh_reg && ((r_dirty & sec_bit) == '0))
                begin
                    if (auth_reg)
                    begin
                        e_copy       = 1'b1;
                        e_valid_next = r_valid | sec_bit;
                    end
                    else if ((r_conf & sec_bit) != '0)
                    begin
                        e_corrupt = 1'b1;
                    end
                    else if ((r_valid & sec_bit) != '0)
                    begin
                        if (!equal_reg)
                        begin
                            e_valid_next = r_valid & ~sec_bit;
                            e_conf_next  = r_conf | sec_bit;
                            e_corrupt    = 1'b1;
                        end
                    end
                    else
                    begin
                        e_copy       = 1'b1;
                        e_valid_next = r_valid | sec_bit;
                    end
                end
            end
            OP_FLUSH_DONE:
            begin
                e_dirty_next = '0;
                e_conf_next  = '0;
            end
            default:
            begin
                e_copy = 1'b0;
            end
        endcase
    end

    assign clock_inc  = clock_reg + SB'(1);
    assign clock_wrap = (clock_inc == '0);
    assign touch_en   = cmd.exec && (op_reg == OP_ACQUIRE) && (hit_reg || !flush_reg);
    assign alloc_en   = touch_en && !hit_reg;

    always_comb
    begin
        any_dirty = 1'b0;
        for (int i = 0; i < TRACK_SLOTS; i++)
        begin
            any_dirty = any_dirty | (|dirty_reg[i]);
        end
    end

    assign zero_rep = bad_slot || (op_reg == OP_DISCARD_ALL) || (op_reg == OP_CLEAR_ALL) ||
                      ((op_reg == OP_NEXT_DIRTY) && !best_found_reg);

    always_comb
    begin
        if (bad_slot || ((op_reg == OP_NEXT_DIRTY) && !best_found_reg))
        begin
            status_next = ST_NONE_FOUND;
        end
        else if ((op_reg == OP_ACQUIRE) && flush_reg)
        begin
            status_next = ST_NEED_FLUSH;
        end
        else if ((op_reg == OP_MERGE_SECTOR) && corrupt_reg)
        begin
            status_next = ST_CORRUPT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    // Command latch and scan trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= OP_ACQUIRE;
            scan_idx_reg    <= '0;
            pick_reg        <= '0;
            hit_reg         <= 1'b0;
            flush_reg       <= 1'b0;
            corrupt_reg     <= 1'b0;
            copy_reg        <= 1'b0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            clean_found_reg <= 1'b0;
            clean_idx_reg   <= '0;
            clean_stamp_reg <= '0;
            vic_found_reg   <= 1'b0;
            vic_idx_reg     <= '0;
            vic_stamp_reg   <= '0;
            best_found_reg  <= 1'b0;
            best_key_reg    <= '0;
        end
        else if (cmd.latch)
        begin
            op_reg          <= opcode_t'(in_opcode);
            scan_idx_reg    <= '0;
            pick_reg        <= '0;
            hit_reg         <= 1'b0;
            flush_reg       <= 1'b0;
            corrupt_reg     <= 1'b0;
            copy_reg        <= 1'b0;
            empty_found_reg <= 1'b0;
            clean_found_reg <= 1'b0;
            vic_found_reg   <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IW'(1);
            if (op_reg == OP_ACQUIRE)
            begin
                if (hit_now)
                begin
                    hit_reg  <= 1'b1;
                    pick_reg <= scan_idx_reg;
                end
                else if (!r_occ)
                begin
                    if (!empty_found_reg)
                    begin
                        empty_found_reg <= 1'b1;
                        empty_idx_reg   <= scan_idx_reg;
                    end
                end
                else if (r_dirty == '0)
                begin
                    if (!clean_found_reg || (r_stamp < clean_stamp_reg))
                    begin
                        clean_found_reg <= 1'b1;
                        clean_idx_reg   <= scan_idx_reg;
                        clean_stamp_reg <= r_stamp;
                    end
                end
                else if (!vic_found_reg || (r_stamp < vic_stamp_reg))
                begin
                    vic_found_reg <= 1'b1;
                    vic_idx_reg   <= scan_idx_reg;
                    vic_stamp_reg <= r_stamp;
                end
            end
            else if ((r_dirty != '0) && (!best_found_reg || (r_key < best_key_reg)))
            begin
                best_found_reg <= 1'b1;
                best_key_reg   <= r_key;
                pick_reg       <= scan_idx_reg;
            end
        end
        else if (cmd.decide)
        begin
            if (empty_found_reg)
            begin
                pick_reg <= empty_idx_reg;
            end
            else if (clean_found_reg)
            begin
                pick_reg <= clean_idx_reg;
            end
            else
            begin
                pick_reg  <= vic_idx_reg;
                flush_reg <= 1'b1;
            end
        end
        else if (cmd.exec && (op_reg == OP_MERGE_SECTOR) && !bad_slot)
        begin
            corrupt_reg <= e_corrupt;
            copy_reg    <= e_copy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cyl_reg   <= in_cylinder;
            head_reg  <= in_head;
            sec_reg   <= in_sector;
            si_reg    <= in_slot_index;
            auth_reg  <= in_authoritative;
            fresh_reg <= in_fresh_present;
            equal_reg <= in_data_equal;
        end
    end

    // Slot state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
            for (int i = 0; i < TRACK_SLOTS; i++)
            begin
                occ_reg[i]      <= 1'b0;
                tag_cyl_reg[i]  <= '0;
                tag_head_reg[i] <= 1'b0;
                stamp_reg[i]    <= '0;
                valid_reg[i]    <= '0;
                dirty_reg[i]    <= '0;
                conf_reg[i]     <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (op_reg == OP_CLEAR_ALL)
            begin
                clock_reg <= '0;
                for (int i = 0; i < TRACK_SLOTS; i++)
                begin
                    occ_reg[i]      <= 1'b0;
                    tag_cyl_reg[i]  <= '0;
                    tag_head_reg[i] <= 1'b0;
                    stamp_reg[i]    <= '0;
                    valid_reg[i]    <= '0;
                    dirty_reg[i]    <= '0;
                    conf_reg[i]     <= '0;
                end
            end
            else if (op_reg == OP_DISCARD_ALL)
            begin
                for (int i = 0; i < TRACK_SLOTS; i++)
                begin
                    valid_reg[i] <= valid_reg[i] & ~dirty_reg[i];
                    dirty_reg[i] <= '0;
                end
            end
            else if (op_slot && !bad_slot)
            begin
                valid_reg[rd_idx] <= e_valid_next;
                dirty_reg[rd_idx] <= e_dirty_next;
                conf_reg[rd_idx]  <= e_conf_next;
            end
            else if (touch_en)
            begin
                if (alloc_en)
                begin
                    occ_reg[rd_idx]      <= 1'b1;
                    tag_cyl_reg[rd_idx]  <= cyl_reg;
                    tag_head_reg[rd_idx] <= head_reg;
                    valid_reg[rd_idx]    <= '0;
                    dirty_reg[rd_idx]    <= '0;
                    conf_reg[rd_idx]     <= '0;
                end
                if (clock_wrap)
                begin
                    // Zero every stamp, restart the clock at one for the touched slot
                    clock_reg <= SB'(1);
                    for (int i = 0; i < TRACK_SLOTS; i++)
                    begin
                        stamp_reg[i] <= (IW'(i) == rd_idx) ? SB'(1) : '0;
                    end
                end
                else
                begin
                    clock_reg         <= clock_inc;
                    stamp_reg[rd_idx] <= clock_inc;
                end
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= status_next;
            rhit_reg   <= (op_reg == OP_ACQUIRE) && hit_reg;
            rcopy_reg  <= (op_reg == OP_MERGE_SECTOR) && copy_reg && !bad_slot;
            rany_reg   <= any_dirty;
            if (zero_rep)
            begin
                slot_reg   <= '0;
                rcyl_reg   <= '0;
                rhead_reg  <= 1'b0;
                rvalid_reg <= '0;
                rdirty_reg <= '0;
            end
            else
            begin
                slot_reg   <= SLOT_W'(rd_idx);
                rcyl_reg   <= r_cyl;
                rhead_reg  <= r_head;
                rvalid_reg <= MASK_W'(r_valid);
                rdirty_reg <= MASK_W'(r_dirty);
            end
        end
    end

    assign stat.op        = op_reg;
    assign stat.bad_slot  = bad_slot;
    assign stat.scan_last = (scan_idx_reg == IW'(TRACK_SLOTS - 1));
    assign stat.hit_now   = hit_now;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid           = out_valid_reg;
    assign out_status          = status_reg;
    assign out_result_slot     = slot_reg;
    assign out_hit             = rhit_reg;
    assign out_victim_cylinder = rcyl_reg;
    assign out_victim_head     = rhead_reg;
    assign out_valid_mask      = rvalid_reg;
    assign out_dirty_mask      = rdirty_reg;
    assign out_copy_data       = rcopy_reg;
    assign out_any_dirty       = rany_reg;

endmodule

>>> rtl/track_cache_slot_policy_core.sv
// Top level of the track cache slot policy block: controller plus datapath.
`timescale 1ns / 1ps
// Tag and state controller for a write-back track cache of TRACK_SLOTS slots.
// Each command item on req yields exactly one result item on rsp. Acquire
// and next_dirty walk the slot table one entry per cycle through a single
// read port, and an acquire hit ends its walk early. One command is in
// flight at a time; a finished result sits in an output register, so the
// next command is taken while the previous result waits. A dirty LRU victim
// is only reported with need_flush; the user flushes it, sends flush_done and
// repeats the acquire. Stamps wrap at 2^STAMP_BITS by zeroing every stamp
// but the touched slot's, which restarts at one.
module track_cache_slot_policy_core
    import tcsp_pkg::*;
#(
    parameter int TRACK_SLOTS       = 8,
    parameter int SECTORS_PER_TRACK = 18,
    parameter int HEAD_COUNT        = 2,
    parameter int STAMP_BITS        = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    tcsp_req_if.sink  req,
    tcsp_rsp_if.source rsp
);

    tcsp_cmd_t  cmd;
    tcsp_stat_t stat;

    // Sequence scan, decide, update and report phases
    tcsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold slot state and build each result item
    tcsp_dp #(
        .TRACK_SLOTS       (TRACK_SLOTS),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
        .HEAD_COUNT        (HEAD_COUNT),
        .STAMP_BITS        (STAMP_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .in_opcode           (req.opcode),
        .in_cylinder         (req.cylinder),
        .in_head             (req.head),
        .in_sector           (req.sector),
        .in_slot_index       (req.slot_index),
        .in_authoritative    (req.authoritative),
        .in_fresh_present    (req.fresh_present),
        .in_data_equal       (req.data_equal),
        .out_ready           (rsp.ready),
        .out_valid           (rsp.valid),
        .out_status          (rsp.status),
        .out_result_slot     (rsp.result_slot),
        .out_hit             (rsp.hit),
        .out_victim_cylinder (rsp.victim_cylinder),
        .out_victim_head     (rsp.victim_head),
        .out_valid_mask      (rsp.valid_mask),
        .out_dirty_mask      (rsp.dirty_mask),
        .out_copy_data       (rsp.copy_data),
        .out_any_dirty       (rsp.any_dirty)
    );

endmodule

>>> rtl/tcsp_checker.sv
// Port-level checks for the track cache slot policy block, with its bind.
`timescale 1ns / 1ps
module tcsp_checker
    import tcsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [2:0]  rsp_result_slot,
    input logic        rsp_hit,
    input logic [17:0] rsp_valid_mask,
    input logic [17:0] rsp_dirty_mask,
    input logic        rsp_copy_data,
    input logic        rsp_any_dirty
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken while another is in flight");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_NONE_FOUND |->
            rsp_result_slot == 3'd0 && rsp_valid_mask == 18'd0 && rsp_dirty_mask == 18'd0)
        else $error("none_found result carries slot data");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_status == ST_OK && !rsp_copy_data)
        else $error("hit with non-ok status");

    a_flush_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_NEED_FLUSH |-> rsp_any_dirty && rsp_dirty_mask != 18'd0)
        else $error("need_flush without dirty victim");

endmodule

bind track_cache_slot_policy_core tcsp_checker u_tcsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_result_slot (rsp.result_slot),
    .rsp_hit         (rsp.hit),
    .rsp_valid_mask  (rsp.valid_mask),
    .rsp_dirty_mask  (rsp.dirty_mask),
    .rsp_copy_data   (rsp.copy_data),
    .rsp_any_dirty   (rsp.any_dirty)
);

>>> tb/tb_track_cache_slot_policy_core.sv
// Self-checking testbench for the track cache slot policy core.
`timescale 1ns / 1ps
module tb_track_cache_slot_policy_core;
    import tcsp_pkg::*;

    localparam int NSLOT    = 8;
    localparam int NSECT    = 18;
    localparam int NRANDOM  = 1150;
    localparam int WD_LIMIT = 20000;
    localparam int TAIL     = 40;
    localparam logic [17:0] SECT_ALL = 18'h3FFFF;

    // One command item and one result item, at the port widths.
    typedef struct packed {
        opcode_t     op;
        logic [7:0]  cyl;
        logic        hd;
        logic [4:0]  sec;
        logic [2:0]  slot;
        logic        auth;
        logic        fresh;
        logic        equal;
    } command_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot;
        logic        hit;
        logic [7:0]  cyl;
        logic        hd;
        logic [17:0] vmask;
        logic [17:0] dmask;
        logic        copy;
        logic        any_dirty;
    } outcome_t;

    // One row of the directed table: a command plus, where it is obvious,
    // the result it must give.
    typedef struct {
        command_t cmd;
        logic     fixed;
        outcome_t want;
    } row_t;

    logic clk;
    logic rst_n;

    tcsp_req_if req ();
    tcsp_rsp_if rsp ();

    track_cache_slot_policy_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Shadow copy of the cache tag and state table.
    logic        occ   [NSLOT];
    logic [7:0]  tcyl  [NSLOT];
    logic        thd   [NSLOT];
    logic [15:0] stamp [NSLOT];
    logic [17:0] vld   [NSLOT];
    logic [17:0] drt   [NSLOT];
    logic [17:0] cfl   [NSLOT];
    logic [15:0] use_clk;

    outcome_t pending_results [$];
    int       mismatches;
    int       results_seen;
    int       cmds_sent;
    int       idle_cycles;
    int       n_flush;
    int       n_corrupt;
    int       n_hit;
    bit       sending_done;

    function automatic void shadow_reset();
        for (int i = 0; i < NSLOT; i++)
        begin
            occ[i]   = 1'b0;
            tcyl[i]  = '0;
            thd[i]   = 1'b0;
            stamp[i] = '0;
            vld[i]   = '0;
            drt[i]   = '0;
            cfl[i]   = '0;
        end
        use_clk = '0;
    endfunction

    // Advance the LRU clock; on wrap zero all stamps and restart at one.
    function automatic void lru_touch(int s);
        use_clk = use_clk + 16'd1;
        if (use_clk == 16'd0)
        begin
            for (int i = 0; i < NSLOT; i++)
                stamp[i] = '0;
            use_clk = 16'd1;
        end
        stamp[s] = use_clk;
    endfunction

    function automatic void fill_report(ref outcome_t r, input int s);
        r.slot  = s[2:0];
        r.cyl   = tcyl[s];
        r.hd    = thd[s];
        r.vmask = vld[s];
        r.dmask = drt[s];
    endfunction

    function automatic outcome_t cache_step(command_t c);
        outcome_t    r;
        int          s;
        int          empty;
        int          clean;
        int          victim;
        int          pick;
        int          found;
        logic [17:0] bit_m;
        int          key;
        int          best;
        r = '{status: ST_OK, default: '0};
        s = c.slot;
        bit_m = (c.sec < NSECT) ? (18'd1 << c.sec) : '0;
        if (c.op inside {OP_WRITE_SECTOR, OP_MERGE_BEGIN, OP_MERGE_SECTOR, OP_FLUSH_DONE}
            && s >= NSLOT)
            r.status = ST_NONE_FOUND;
        else
        begin
            case (c.op)
                OP_ACQUIRE:
                begin
                    empty = -1; clean = -1; victim = -1; found = -1;
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (occ[i] && tcyl[i] == c.cyl && thd[i] == c.hd)
                        begin
                            found = i;
                            break;
                        end
                        if (!occ[i])
                        begin
                            if (empty < 0) empty = i;
                        end
                        else if (drt[i] == '0)
                        begin
                            if (clean < 0 || stamp[i] < stamp[clean]) clean = i;
                        end
                        else if (victim < 0 || stamp[i] < stamp[victim])
                            victim = i;
                    end
                    if (found >= 0)
                    begin
                        lru_touch(found);
                        r.hit = 1'b1;
                        n_hit++;
                        fill_report(r, found);
                    end
                    else
                    begin
                        pick = (empty >= 0) ? empty : (clean >= 0) ? clean : victim;
                        if (pick == victim && victim >= 0)
                        begin
                            r.status = ST_NEED_FLUSH;
                            n_flush++;
                            fill_report(r, victim);
                        end
                        else if (pick >= 0)
                        begin
                            occ[pick]  = 1'b1;
                            tcyl[pick] = c.cyl;
                            thd[pick]  = c.hd;
                            vld[pick]  = '0;
                            drt[pick]  = '0;
                            cfl[pick]  = '0;
                            lru_touch(pick);
                            fill_report(r, pick);
                        end
                    end
                end
                OP_WRITE_SECTOR:
                begin
                    vld[s] |= bit_m;
                    drt[s] |= bit_m;
                    cfl[s] &= ~bit_m;
                    fill_report(r, s);
                end
                OP_MERGE_BEGIN:
                begin
                    if (c.auth) cfl[s] = '0;
                    fill_report(r, s);
                end
                OP_MERGE_SECTOR:
                begin
                    // Skip sectors absent from the fresh read or dirty here.
                    if (bit_m != '0 && c.fresh && (drt[s] & bit_m) == '0)
                    begin
                        if (c.auth)
                        begin
                            r.copy = 1'b1;
                            vld[s] |= bit_m;
                        end
                        else if ((cfl[s] & bit_m) != '0)
                            r.status = ST_CORRUPT;
                        else if ((vld[s] & bit_m) != '0)
                        begin
                            if (!c.equal)
                            begin
                                vld[s] &= ~bit_m;
                                cfl[s] |= bit_m;
                                r.status = ST_CORRUPT;
                            end
                        end
                        else
                        begin
                            r.copy = 1'b1;
                            vld[s] |= bit_m;
                        end
                    end
                    if (r.status == ST_CORRUPT) n_corrupt++;
                    fill_report(r, s);
                end
                OP_FLUSH_DONE:
                begin
                    drt[s] = '0;
                    cfl[s] = '0;
                    fill_report(r, s);
                end
                OP_NEXT_DIRTY:
                begin
                    pick = -1;
                    best = 0;
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if ((drt[i] & SECT_ALL) == '0) continue;
                        key = int'(tcyl[i]) * 2 + int'(thd[i]);
                        if (pick < 0 || key < best)
                        begin
                            pick = i;
                            best = key;
                        end
                    end
                    if (pick < 0) r.status = ST_NONE_FOUND;
                    else fill_report(r, pick);
                end
                OP_DISCARD_ALL:
                begin
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        vld[i] &= ~drt[i];
                        drt[i] = '0;
                    end
                end
                default:
                    shadow_reset();
            endcase
        end
        for (int i = 0; i < NSLOT; i++)
            if ((drt[i] & SECT_ALL) != '0) r.any_dirty = 1'b1;
        return r;
    endfunction

    function automatic command_t mk(opcode_t op, int cyl, int hd, int sec, int slot,
                                    int auth, int fresh, int equal);
        command_t c;
        c.op = op; c.cyl = cyl[7:0]; c.hd = hd[0]; c.sec = sec[4:0];
        c.slot = slot[2:0]; c.auth = auth[0]; c.fresh = fresh[0]; c.equal = equal[0];
        return c;
    endfunction

    function automatic outcome_t zero_out(status_t st);
        outcome_t r;
        r = '{status: st, default: '0};
        return r;
    endfunction

    // Random command, mostly well-formed traffic around a small set of tracks
    // so that hits, victims, conflicts and flush sequences come up often.
    function automatic command_t rand_cmd();
        command_t c;
        int       k;
        c = mk(OP_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 1),
               $urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 1),
               $urandom_range(0, 1), $urandom_range(0, 1));
        if ($urandom_range(0, 9) < 8)
        begin
            c.cyl = ($urandom_range(0, 15) == 0) ? c.cyl : 8'($urandom_range(0, 5));
            c.sec = ($urandom_range(0, 9) == 0) ? c.sec : 5'($urandom_range(0, 17));
        end
        k = $urandom_range(0, 99);
        if (k < 28)      c.op = OP_ACQUIRE;
        else if (k < 48) c.op = OP_WRITE_SECTOR;
        else if (k < 56) c.op = OP_MERGE_BEGIN;
        else if (k < 76) c.op = OP_MERGE_SECTOR;
        else if (k < 86) c.op = OP_FLUSH_DONE;
        else if (k < 95) c.op = OP_NEXT_DIRTY;
        else if (k < 98) c.op = OP_DISCARD_ALL;
        else             c.op = OP_CLEAR_ALL;
        return c;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drive one item and hold it until accepted; drop valid only across a gap.
    task automatic send_cmd(command_t c);
        int g;
        g = (cmds_sent < 40 || (cmds_sent > 600 && cmds_sent < 700)) ? 0 : gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.opcode        <= c.op;
        req.cylinder      <= c.cyl;
        req.head          <= c.hd;
        req.sector        <= c.sec;
        req.slot_index    <= c.slot;
        req.authoritative <= c.auth;
        req.fresh_present <= c.fresh;
        req.data_equal    <= c.equal;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        pending_results.push_back(cache_step(c));
        cmds_sent++;
    endtask

    row_t directed [$];

    task automatic add_row(command_t c, logic fixed, outcome_t w);
        row_t r;
        r.cmd = c; r.fixed = fixed; r.want = w;
        directed.push_back(r);
    endtask

    task automatic check_result();
        outcome_t got;
        outcome_t exp_r;
        got.status = status_t'(rsp.status);
        got.slot = rsp.result_slot;      got.hit = rsp.hit;
        got.cyl = rsp.victim_cylinder;   got.hd = rsp.victim_head;
        got.vmask = rsp.valid_mask;      got.dmask = rsp.dirty_mask;
        got.copy = rsp.copy_data;        got.any_dirty = rsp.any_dirty;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %0d", results_seen);
            return;
        end
        exp_r = pending_results.pop_front();
        if (got != exp_r)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("item %0d: exp st=%0d sl=%0d hit=%0d c=%0d h=%0d v=%h d=%h cp=%0d ad=%0d ; got st=%0d sl=%0d hit=%0d c=%0d h=%0d v=%h d=%h cp=%0d ad=%0d",
                         results_seen, exp_r.status, exp_r.slot, exp_r.hit, exp_r.cyl,
                         exp_r.hd, exp_r.vmask, exp_r.dmask, exp_r.copy, exp_r.any_dirty,
                         got.status, got.slot, got.hit, got.cyl, got.hd, got.vmask,
                         got.dmask, got.copy, got.any_dirty);
        end
    endtask

    // Stimulus: directed table, dirty-victim flush sequence, then random traffic with a drain pause.
    initial
    begin
        outcome_t zr;
        outcome_t model;
        zr = zero_out(ST_OK);
        shadow_reset();
        mismatches = 0; results_seen = 0; cmds_sent = 0;
        n_flush = 0; n_corrupt = 0; n_hit = 0;
        sending_done = 1'b0;
        req.valid <= 1'b0; req.opcode <= OP_ACQUIRE; req.cylinder <= '0;
        req.head <= 1'b0; req.sector <= '0; req.slot_index <= '0;
        req.authoritative <= 1'b0; req.fresh_present <= 1'b0; req.data_equal <= 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty cache: nothing dirty, bulk commands report zero.
        add_row(mk(OP_NEXT_DIRTY, 0, 0, 0, 0, 0, 0, 0), 1, zero_out(ST_NONE_FOUND));
        add_row(mk(OP_DISCARD_ALL, 0, 0, 0, 0, 0, 0, 0), 1, zr);
        // Extreme tags on acquire.
        add_row(mk(OP_ACQUIRE, 255, 1, 31, 7, 1, 1, 1), 0, zr);
        add_row(mk(OP_ACQUIRE, 0, 0, 0, 0, 0, 0, 0), 0, zr);
        add_row(mk(OP_ACQUIRE, 255, 1, 0, 0, 0, 0, 0), 0, zr);
        // Writes at both sector ends and one out of range.
        add_row(mk(OP_WRITE_SECTOR, 0, 0, 0, 0, 0, 0, 0), 0, zr);
        add_row(mk(OP_WRITE_SECTOR, 0, 0, 17, 0, 0, 0, 0), 0, zr);
        add_row(mk(OP_WRITE_SECTOR, 0, 0, 31, 0, 0, 0, 0), 0, zr);
        add_row(mk(OP_MERGE_SECTOR, 0, 0, 25, 1, 1, 1, 0), 0, zr);
        // Merge rules on slot 1 (clean).
        add_row(mk(OP_MERGE_BEGIN, 0, 0, 0, 1, 0, 0, 0), 0, zr);
        add_row(mk(OP_MERGE_SECTOR, 0, 0, 3, 1, 0, 1, 1), 0, zr);
        add_row(mk(OP_MERGE_SECTOR, 0, 0, 3, 1, 0, 1, 0), 0, zr);
        add_row(mk(OP_MERGE_SECTOR, 0, 0, 3, 1, 0, 1, 1), 0, zr);
        add_row(mk(OP_MERGE_SECTOR, 0, 0, 4, 1, 0, 0, 0), 0, zr);
        add_row(mk(OP_MERGE_BEGIN, 0, 0, 0, 1, 1, 0, 0), 0, zr);
        add_row(mk(OP_MERGE_SECTOR, 0, 0, 3, 1, 1, 1, 0), 0, zr);
        add_row(mk(OP_MERGE_SECTOR, 0, 0, 0, 0, 1, 1, 0), 0, zr);
        // Highest slot index, then flush and bulk commands down to empty.
        add_row(mk(OP_WRITE_SECTOR, 0, 0, 0, 7, 0, 0, 0), 0, zr);
        add_row(mk(OP_NEXT_DIRTY, 0, 0, 0, 0, 0, 0, 0), 0, zr);
        add_row(mk(OP_FLUSH_DONE, 0, 0, 0, 0, 0, 0, 0), 0, zr);
        add_row(mk(OP_DISCARD_ALL, 0, 0, 0, 0, 0, 0, 0), 1, zr);
        add_row(mk(OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0), 1, zr);
        add_row(mk(OP_NEXT_DIRTY, 0, 0, 0, 0, 0, 0, 0), 1, zero_out(ST_NONE_FOUND));

        foreach (directed[i])
        begin
            send_cmd(directed[i].cmd);
            // Replace the prediction with the typed-in value; the two must agree.
            if (directed[i].fixed)
            begin
                model = pending_results.pop_back();
                if (model != directed[i].want)
                begin
                    mismatches++;
                    $display("directed row %0d: predictor disagrees with table", i);
                end
                pending_results.push_back(directed[i].want);
            end
        end

        // Fill all eight slots dirty to force need_flush, then flush and retry.
        for (int i = 0; i < NSLOT; i++)
        begin
            send_cmd(mk(OP_ACQUIRE, 100 + i, 0, 0, 0, 0, 0, 0));
            send_cmd(mk(OP_WRITE_SECTOR, 0, 0, i, i, 0, 0, 0));
        end
        send_cmd(mk(OP_ACQUIRE, 200, 1, 0, 0, 0, 0, 0));
        send_cmd(mk(OP_NEXT_DIRTY, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(OP_FLUSH_DONE, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(OP_ACQUIRE, 200, 1, 0, 0, 0, 0, 0));

        for (int n = 0; n < NRANDOM; n++)
        begin
            if (n == NRANDOM / 2)
            begin
                // Hold off until every pending result has come back.
                req.valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            send_cmd(rand_cmd());
        end
        req.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Result side: random stalls, compare with the oldest expectation.
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                check_result();
            rsp.ready <= ($urandom_range(0, 99) < 70 || cmds_sent < 40);
        end
    end

    // Watchdog and end of run.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("timeout: %0d results outstanding", pending_results.size());
                $display("CHECK FAILED");
                $finish;
            end
            if (sending_done && pending_results.size() == 0)
            begin
                repeat (TAIL) @(posedge clk);
                $display("covered %0d commands: %0d hits, %0d need_flush, %0d corrupt merges",
                         cmds_sent, n_hit, n_flush, n_corrupt);
                $display("directed table, dirty-victim flush cycle, random traffic with a drain");
                if (mismatches == 0 && rsp.valid == 1'b0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
